// ===== hw/rtl/mau_pkg.sv =====
// shared types and constants for the modular arithmetic unit
package mau_pkg;
   localparam int MOD_BITS_DEF = 31;
   localparam logic [30:0] MODULUS_RESET = 31'd1000000007;

   typedef enum logic [2:0] {
      ACT_ADD = 3'd0,
      ACT_SUB = 3'd1,
      ACT_MUL = 3'd2,
      ACT_POW = 3'd3,
      ACT_INV = 3'd4
   } action_type;
endpackage

// ===== hw/rtl/mau_reduce.sv =====
// restoring remainder unit, one quotient bit per cycle
module mau_reduce #(
   parameter int MOD_BITS = mau_pkg::MOD_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [MOD_BITS-1:0] value,
   input  logic [MOD_BITS-1:0] modulus,
   output logic                done,
   output logic [MOD_BITS-1:0] remainder
);
   localparam int CW = $clog2(MOD_BITS + 1);
   logic [MOD_BITS:0]   rem_ff, rem_in;
   logic [MOD_BITS-1:0] val_ff, val_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                busy_ff, busy_in, done_ff, done_in;
   logic [MOD_BITS+1:0] shifted;

   always_comb begin
      rem_in = rem_ff;
      val_in = val_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff, val_ff[MOD_BITS-1]};
      if (start) begin
         rem_in = '0;
         val_in = value;
         cnt_in = CW'(MOD_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (shifted >= {2'b00, modulus})
            rem_in = (MOD_BITS+1)'(shifted - {2'b00, modulus});
         else
            rem_in = (MOD_BITS+1)'(shifted);
         val_in = {val_ff[MOD_BITS-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      val_ff <= val_in;
   end

   assign done = done_ff;
   assign remainder = rem_ff[MOD_BITS-1:0];
endmodule

// ===== hw/rtl/mau_mul.sv =====
// bit-serial shift and add modular multiplier
module mau_mul #(
   parameter int MOD_BITS = mau_pkg::MOD_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [MOD_BITS-1:0] x,
   input  logic [MOD_BITS-1:0] y,
   input  logic [MOD_BITS-1:0] modulus,
   output logic                done,
   output logic [MOD_BITS-1:0] product
);
   localparam int CW = $clog2(MOD_BITS + 1);
   logic [MOD_BITS-1:0] acc_ff, acc_in, x_ff, x_in, y_ff, y_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                busy_ff, busy_in, done_ff, done_in;
   logic [MOD_BITS:0]   dbl, add;
   logic [MOD_BITS-1:0] acc2;

   always_comb begin
      acc_in = acc_ff;
      x_in = x_ff;
      y_in = y_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      dbl = {acc_ff, 1'b0};
      acc2 = (dbl >= {1'b0, modulus}) ? MOD_BITS'(dbl - {1'b0, modulus})
                                      : MOD_BITS'(dbl);
      add = {1'b0, acc2} + {1'b0, x_ff};
      if (start) begin
         acc_in = '0;
         x_in = x;
         y_in = y;
         cnt_in = CW'(MOD_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (y_ff[MOD_BITS-1])
            acc_in = (add >= {1'b0, modulus}) ? MOD_BITS'(add - {1'b0, modulus})
                                              : MOD_BITS'(add);
         else
            acc_in = acc2;
         y_in = {y_ff[MOD_BITS-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      acc_ff <= acc_in;
      x_ff <= x_in;
      y_ff <= y_in;
   end

   assign done = done_ff;
   assign product = acc_ff;
endmodule

// ===== hw/rtl/modular_arithmetic_unit_core.sv =====
// Modular arithmetic unit: add, subtract, multiply, power and Fermat inverse.
// Items arrive on the req_ stream (tdata: action, operand_a, operand_b), one
// result leaves on the rsp_ stream (tdata: result). The modulus is written
// over the csr_ APB port at address 0 and reads back there; reset loads
// 1000000007. The block takes one item at a time: req_tready is high only
// while no item is in work and no result is waiting.
// Each operand is reduced in a one-bit-per-cycle remainder unit; add, subtract
// and multiply reduce both operands, power and inverse only the base. Add and
// subtract then finish in the execute state, multiply runs one bit-serial
// multiply. Power and inverse take, per exponent bit, one or two bit-serial
// multiplies on the shared multiplier.
// The result is held on rsp_tdata until the receiver takes it; a stalled
// receiver holds the block. Reset is synchronous and drops any item in work.
module modular_arithmetic_unit_core #(
   parameter int MOD_BITS = mau_pkg::MOD_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // action [2:0], operand_a, operand_b, zero fill
   input  logic [((3+2*MOD_BITS+7)/8)*8-1:0] req_tdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // result, zero fill
   output logic [((MOD_BITS+7)/8)*8-1:0] rsp_tdata,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [(MOD_BITS>32 ? 3 : 2)-1:0] csr_paddr,
   input  logic [(MOD_BITS>32 ? 64 : 32)-1:0] csr_pwdata,
   output logic [(MOD_BITS>32 ? 64 : 32)-1:0] csr_prdata,
   output logic                csr_pready
);
   localparam int DW = (MOD_BITS > 32) ? 64 : 32;
   localparam int AW = (MOD_BITS > 32) ? 3 : 2;
   localparam int OW = ((MOD_BITS + 7) / 8) * 8;
   localparam logic [MOD_BITS-1:0] MOD_RESET =
      MOD_BITS'(64'(mau_pkg::MODULUS_RESET) & ((64'd1 << MOD_BITS) - 64'd1));

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_REDA = 8'b0000_0010,
      ST_REDB = 8'b0000_0100,
      ST_EXEC = 8'b0000_1000,
      ST_PMUL = 8'b0001_0000,
      ST_PSQR = 8'b0010_0000,
      ST_WAIT = 8'b0100_0000,
      ST_OUT  = 8'b1000_0000
   } state_type;

   state_type           state_ff, state_in;
   logic [MOD_BITS-1:0] mod_ff, mod_in;
   logic [2:0]          act_ff, act_in;
   logic [MOD_BITS-1:0] a_ff, a_in, b_ff, b_in, e_ff, e_in, acc_ff, acc_in;
   logic [MOD_BITS-1:0] res_ff, res_in;
   logic                red_start, red_done;
   logic [MOD_BITS-1:0] red_val, red_rem;
   logic                mul_start, mul_done;
   logic [MOD_BITS-1:0] mul_x, mul_y, mul_p;
   logic [MOD_BITS:0]   sum;
   logic [MOD_BITS-1:0] room;
   logic                csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr == AW'(0)) ? DW'(mod_ff) : '0;
   assign mod_in = (csr_wr && csr_paddr == AW'(0)) ? csr_pwdata[MOD_BITS-1:0] : mod_ff;

   mau_reduce #(.MOD_BITS(MOD_BITS)) u_reduce (
      .clock(clock), .reset(reset), .start(red_start), .value(red_val),
      .modulus(mod_ff), .done(red_done), .remainder(red_rem)
   );

   mau_mul #(.MOD_BITS(MOD_BITS)) u_mul (
      .clock(clock), .reset(reset), .start(mul_start), .x(mul_x), .y(mul_y),
      .modulus(mod_ff), .done(mul_done), .product(mul_p)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata = OW'(res_ff);

   always_comb begin
      state_in = state_ff;
      act_in = act_ff;
      a_in = a_ff;
      b_in = b_ff;
      e_in = e_ff;
      acc_in = acc_ff;
      res_in = res_ff;
      red_start = 1'b0;
      red_val = a_ff;
      mul_start = 1'b0;
      mul_x = acc_ff;
      mul_y = a_ff;
      room = mod_ff - a_ff;
      sum = {1'b0, a_ff} + {1'b0, b_ff};
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               act_in = req_tdata[2:0];
               a_in = req_tdata[3 +: MOD_BITS];
               b_in = req_tdata[3+MOD_BITS +: MOD_BITS];
               if (mod_ff < MOD_BITS'(2) || req_tdata[2:0] > 3'(mau_pkg::ACT_INV)) begin
                  res_in = '0;
                  state_in = ST_OUT;
               end else begin
                  red_start = 1'b1;
                  red_val = req_tdata[3 +: MOD_BITS];
                  state_in = ST_REDA;
               end
            end
         end
         ST_REDA: begin
            if (red_done) begin
               a_in = red_rem;
               if (act_ff == 3'(mau_pkg::ACT_POW)) begin
                  e_in = b_ff;
                  acc_in = MOD_BITS'(1);
                  state_in = ST_EXEC;
               end else if (act_ff == 3'(mau_pkg::ACT_INV)) begin
                  e_in = mod_ff - MOD_BITS'(2);
                  acc_in = MOD_BITS'(1);
                  state_in = ST_EXEC;
               end else begin
                  red_start = 1'b1;
                  red_val = b_ff;
                  state_in = ST_REDB;
               end
            end
         end
         ST_REDB: begin
            if (red_done) begin
               b_in = red_rem;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            unique case (act_ff)
               3'(mau_pkg::ACT_ADD): begin
                  res_in = (b_ff >= room) ? b_ff - room : MOD_BITS'(sum);
                  state_in = ST_OUT;
               end
               3'(mau_pkg::ACT_SUB): begin
                  res_in = (a_ff >= b_ff) ? a_ff - b_ff : a_ff + (mod_ff - b_ff);
                  state_in = ST_OUT;
               end
               3'(mau_pkg::ACT_MUL): begin
                  mul_start = 1'b1;
                  mul_x = a_ff;
                  mul_y = b_ff;
                  state_in = ST_WAIT;
               end
               default: begin
                  if (e_ff == '0) begin
                     res_in = acc_ff;
                     state_in = ST_OUT;
                  end else if (e_ff[0]) begin
                     mul_start = 1'b1;
                     state_in = ST_PMUL;
                  end else begin
                     mul_start = 1'b1;
                     mul_x = a_ff;
                     state_in = ST_PSQR;
                  end
               end
            endcase
         end
         ST_PMUL: begin
            if (mul_done) begin
               acc_in = mul_p;
               mul_start = 1'b1;
               mul_x = a_ff;
               state_in = ST_PSQR;
            end
         end
         ST_PSQR: begin
            if (mul_done) begin
               a_in = mul_p;
               e_in = e_ff >> 1;
               state_in = ST_EXEC;
            end
         end
         ST_WAIT: begin
            if (mul_done) begin
               res_in = mul_p;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mod_ff <= MOD_RESET;
      end else begin
         state_ff <= state_in;
         mod_ff <= mod_in;
      end
      act_ff <= act_in;
      a_ff <= a_in;
      b_ff <= b_in;
      e_ff <= e_in;
      acc_ff <= acc_in;
      res_ff <= res_in;
   end
endmodule
